[rtl/core/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication in the next cycle outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/core/smpq_pkg.sv]
// Shared types, constants and helpers of the sorted min priority queue
package smpq_pkg;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] head_value;
        logic        is_empty;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

    // IEEE ordered less-than on single bit patterns
    function automatic logic f32_less(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a;
        logic        nan_b;
        logic [31:0] ka;
        logic [31:0] kb;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        if (nan_a || nan_b) begin
            return 1'b0;
        end
        if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
            return 1'b0;
        end
        return ka < kb;
    endfunction
endpackage

[rtl/core/smpq_ctrl.sv]
// Controller state machine of the sorted min priority queue
module smpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  smpq_pkg::t_sts  i_sts,
    output smpq_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    import smpq_pkg::*;

    t_state r_state;
    t_state n_state;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN: begin
                o_cmd.step   = !i_sts.scan_done;
                o_cmd.commit = i_sts.scan_done;
            end
            S_DONE: o_done = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end
endmodule

[rtl/core/smpq_dp.sv]
// Datapath of the sorted min priority queue: store, insertion scan and shifts
module smpq_dp #(
    parameter int DEPTH = smpq_pkg::DEFAULT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smpq_pkg::t_cmd      i_cmd,
    input  smpq_pkg::t_in_item  i_item,
    output smpq_pkg::t_sts      o_sts,
    output smpq_pkg::t_out_item o_result
);
    import smpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_rd;
    logic [1:0]    r_kind;
    logic [31:0]   r_val;
    logic [CW-1:0] r_pos;
    logic          r_found;
    logic          r_shift;
    logic [31:0]   r_carry;
    logic [1:0]    r_stat;

    logic          full;
    logic          scan_end;

    assign full     = (r_count == CW'(DEPTH));
    assign scan_end = (r_idx >= r_count);
    assign o_sts.scan_done = scan_end && !r_shift;

    // Walk the store one entry per cycle: a push searches and carries entries up, a pop shifts entries down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_shift <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_kind  <= i_item.kind;
            r_val   <= i_item.value;
            r_stat  <= ST_OK;
            r_found <= 1'b0;
            r_shift <= 1'b0;
            r_pos   <= r_count;
            r_carry <= i_item.value;
            // Pop reads from entry 1; push reads from entry 0
            if (i_item.kind == KIND_PUSH && !full && r_count != '0) begin
                r_idx <= '0;
                r_rd  <= r_mem[0];
            end else if (i_item.kind == KIND_POP && r_count > CW'(1)) begin
                r_idx <= CW'(1);
                r_rd  <= r_mem[1];
                r_shift <= 1'b1;
            end else begin
                r_idx <= r_count;
            end
        end else if (i_cmd.step) begin
            if (r_kind == KIND_POP) begin
                // Move entry idx down to idx-1
                r_mem[AW'(r_idx - CW'(1))] <= r_rd;
                if (r_idx + CW'(1) < r_count) begin
                    r_rd <= r_mem[AW'(r_idx + CW'(1))];
                end else begin
                    r_shift <= 1'b0;
                end
                r_idx <= r_idx + CW'(1);
            end else begin
                // Insert: once the slot is found, write carry and carry the old entry up
                if (r_found || f32_less(r_val, r_rd)) begin
                    r_found <= 1'b1;
                    r_mem[AW'(r_idx)] <= r_carry;
                    r_carry <= r_rd;
                end
                r_idx <= r_idx + CW'(1);
                if (r_idx + CW'(1) < r_count) begin
                    r_rd <= r_mem[AW'(r_idx + CW'(1))];
                end
            end
        end else if (i_cmd.commit) begin
            unique case (r_kind)
                KIND_PUSH: begin
                    if (full) begin
                        r_stat <= ST_FULL;
                    end else begin
                        r_mem[AW'(r_count)] <= r_carry;
                        r_count <= r_count + CW'(1);
                    end
                end
                KIND_POP: begin
                    if (r_count != '0) r_count <= r_count - CW'(1);
                end
                KIND_PEEK: begin
                    if (r_count == '0) r_stat <= ST_EMPTY;
                end
                KIND_CLEAR: r_count <= '0;
                default: r_count <= r_count;
            endcase
        end
    end

    // Track the head entry alongside the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_kind == KIND_PUSH && !full) begin
                if (r_count == '0 || (r_found && r_pos == '0)) r_head <= r_val;
                else if (r_found) r_head <= r_head;
            end else if (r_kind == KIND_POP && r_count > CW'(1)) begin
                r_head <= r_mem[0];
            end
        end else if (i_cmd.step && r_kind == KIND_PUSH && !r_found
                     && r_idx == '0 && f32_less(r_val, r_rd)) begin
            r_head <= r_val;
        end
    end

    // Present the result registers
    always_comb begin
        o_result.is_empty   = (r_count == '0);
        o_result.head_value = (r_count == '0) ? 32'd0 : r_head;
        o_result.status     = r_stat;
        o_result.occupancy  = 5'(r_count);
    end
endmodule

[rtl/core/sorted_min_priority_queue.sv]
// Top level of the sorted min priority queue
// A command (push, pop, peek, clear) is taken when start is high and busy
// is low. The store is walked one entry per cycle through a single read port:
// the command is loaded, the scan steps through the stored entries that a push
// or pop needs, the result is committed, and o_done then shows it. The result
// appears for one cycle with o_done and cannot be stalled.
module sorted_min_priority_queue #(
    parameter int DEPTH = smpq_pkg::DEFAULT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  smpq_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output smpq_pkg::t_out_item o_result
);
    import smpq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smpq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy),
        .o_done (o_done)
    );

    smpq_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .o_sts   (sts),
        .o_result(o_result)
    );
endmodule

[rtl/core/smpq_checker.sv]
// Port checker for the sorted min priority queue, bound to the top level
`include "assert_macros.svh"
module smpq_port_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input smpq_pkg::t_out_item o_result
);
    import smpq_pkg::*;
    `ASSERT_IMPL(a_empty_head, i_clk, i_rst_n, o_done && o_result.is_empty, o_result.head_value == '0)
    `ASSERT_IMPL(a_empty_occ, i_clk, i_rst_n, o_done, o_result.is_empty == (o_result.occupancy == '0))
    `ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
endmodule

bind sorted_min_priority_queue smpq_port_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_result(o_result)
);
